FILE: hdl/csrb_pkg.sv
// Shared types, constants and register codes for the clipped sprite row blitter.
package csrb_pkg;

	// Screen and stream geometry
	localparam int SCREEN_W   = 640;
	localparam int SCREEN_H   = 480;
	localparam int HDR_BYTES  = 16;
	localparam int HDR_POS_W  = $clog2(HDR_BYTES + 1);

	// Field widths
	localparam int COORD_W    = 17;  // sprite column sums (16 bit + 16 bit)
	localparam int X_W        = 10;
	localparam int Y_W        = 9;
	localparam int LEN_W      = 10;
	localparam int COLOUR_W   = 8;
	localparam int OUT_DATA_W = 40;  // 37 payload bits padded to whole bytes
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 3;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_CLIP_LEFT   = 3'd2,
		REG_CLIP_RIGHT  = 3'd3,
		REG_CLIP_TOP    = 3'd4,
		REG_CLIP_BOTTOM = 3'd5,
		REG_TRANSPARENT = 3'd6
	} cfg_reg_t;

	// Span request over sprite columns [col_a, col_b) of one row
	typedef struct packed {
		logic                en;
		logic [COORD_W-1:0]  col_a;
		logic [COORD_W-1:0]  col_b;
		logic [COLOUR_W-1:0] colour;
	} span_req_t;

	// Clipped screen span
	typedef struct packed {
		logic                ok;
		logic [X_W-1:0]      x;
		logic [Y_W-1:0]      y;
		logic [LEN_W-1:0]    len;
		logic [COLOUR_W-1:0] colour;
	} span_t;

endpackage

FILE: hdl/clipped_sprite_row_blitter_core.sv
// Sprite byte stream parser and span clipper producing framebuffer span writes.
//
//  channel   | direction | tdata / tuser / tlast               | per request
//  s_axis    | in        | sprite_byte / first_byte / -        | one stream byte
//  m_axis    | out       | x, y, length, colour / - / last     | one span, 0 to 2 per byte
//  cfg       | in        | cfg_index selects, cfg_wdata value  | one register write
//
// One byte is taken per cycle while s_axis_tready is high. The parse counters update
// in the accept cycle, the span requests are registered in stage 1, clipped into the
// stage 2 result register, and shown on m_axis from there.
// A byte that causes two spans holds the result register until both spans have left;
// bytes keep entering as long as stage 1 can move into stage 2.
// Reset clears the configuration to its defaults and leaves the parser idle.
module clipped_sprite_row_blitter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// sprite_byte[7:0]
	input  logic [7:0]                         s_axis_tdata,
	// first_byte[0]
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// span_x[9:0], span_y[18:10], span_length[28:19], span_colour[36:29], zero[39:37]
	output logic [csrb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic                               cfg_we,
	input  logic [csrb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csrb_pkg::CFG_W-1:0]         cfg_wdata
);

	// Configuration registers
	logic [10:0] origin_x_q;
	logic [10:0] origin_y_q;
	logic [10:0] clip_left_q;
	logic [10:0] clip_right_q;
	logic [9:0]  clip_top_q;
	logic [9:0]  clip_bottom_q;
	logic [8:0]  transparent_q;

	// Parser state
	logic [csrb_pkg::HDR_POS_W-1:0] hdr_pos_q;
	logic [15:0] width_q, height_q, row_q, start_q, count_q, seen_q;
	logic [1:0]  rhp_q;
	logic        in_run_q;

	// Parser next state
	logic [csrb_pkg::HDR_POS_W-1:0] e_hdr, n_hdr;
	logic [15:0] e_width, e_height, e_row, e_start, e_count, e_seen;
	logic [15:0] n_width, n_height, n_row, n_start, n_count, n_seen;
	logic [1:0]  e_rhp, n_rhp;
	logic        e_in_run, n_in_run;
	logic [csrb_pkg::COORD_W-1:0] col, col_p1, stop, seen_p1;
	logic [15:0] lead;
	csrb_pkg::span_req_t req0, req1;

	// Pipeline
	logic                s_accept, m_accept, s2_free;
	logic                valid_s1;
	csrb_pkg::span_req_t req0_s1, req1_s1;
	logic [15:0]         row_s1;
	csrb_pkg::span_t     clip0, clip1;
	csrb_pkg::span_t     res0_s2, res1_s2;
	csrb_pkg::span_t     out_span;

	// Clip one span request against the window, the screen and the transparent colour
	function automatic csrb_pkg::span_t clip_span(
		input csrb_pkg::span_req_t r,
		input logic [15:0]         row,
		input logic [10:0]         ox,
		input logic [10:0]         oy,
		input logic [10:0]         cl,
		input logic [10:0]         cr,
		input logic [9:0]          ct,
		input logic [9:0]          cb,
		input logic [8:0]          tr
	);
		csrb_pkg::span_t s;
		logic [9:0]  x1, x2, xmax;
		logic [8:0]  y1, y2;
		logic [17:0] ry;
		logic [18:0] lo, hi, lo_c, hi_c, len;
		logic        row_ok, col_ok;
		x1   = cl[10] ? 10'd0 : cl[9:0];
		x2   = cr[10] ? 10'(csrb_pkg::SCREEN_W - 1) : cr[9:0];
		xmax = (x2 > 10'(csrb_pkg::SCREEN_W - 1)) ? 10'(csrb_pkg::SCREEN_W - 1) : x2;
		y1   = ct[9] ? 9'd0 : ct[8:0];
		y2   = cb[9] ? 9'(csrb_pkg::SCREEN_H - 1) : cb[8:0];
		ry   = {{7{oy[10]}}, oy} + {2'b00, row};
		row_ok = !ry[17] && (ry[16:0] >= {8'd0, y1}) && (ry[16:0] <= {8'd0, y2})
			&& (ry[16:0] < 17'(csrb_pkg::SCREEN_H));
		lo   = {{8{ox[10]}}, ox} + {2'b00, r.col_a};
		hi   = {{8{ox[10]}}, ox} + {2'b00, r.col_b} - 19'd1;
		lo_c = ($signed(lo) < $signed({9'd0, x1})) ? {9'd0, x1} : lo;
		hi_c = ($signed(hi) > $signed({9'd0, xmax})) ? {9'd0, xmax} : hi;
		col_ok = ($signed(lo_c) <= $signed(hi_c));
		len  = hi_c - lo_c + 19'd1;
		s.ok     = r.en && (r.col_a < r.col_b) && row_ok && col_ok
			&& ({1'b0, r.colour} != tr);
		s.x      = lo_c[csrb_pkg::X_W-1:0];
		s.y      = ry[csrb_pkg::Y_W-1:0];
		s.len    = len[csrb_pkg::LEN_W-1:0];
		s.colour = r.colour;
		return s;
	endfunction

	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign m_accept = m_axis_tvalid && m_axis_tready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			clip_left_q   <= '1;
			clip_right_q  <= '1;
			clip_top_q    <= '1;
			clip_bottom_q <= '1;
			transparent_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csrb_pkg::REG_ORIGIN_X:    origin_x_q    <= cfg_wdata;
				csrb_pkg::REG_ORIGIN_Y:    origin_y_q    <= cfg_wdata;
				csrb_pkg::REG_CLIP_LEFT:   clip_left_q   <= cfg_wdata;
				csrb_pkg::REG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata;
				csrb_pkg::REG_CLIP_TOP:    clip_top_q    <= cfg_wdata[9:0];
				csrb_pkg::REG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata[9:0];
				csrb_pkg::REG_TRANSPARENT: transparent_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// Advance the parser for the incoming byte and form its span requests
	always_comb begin
		if (s_axis_tuser) begin
			e_hdr    = '0;
			e_width  = '0;
			e_height = '0;
			e_row    = '0;
			e_start  = '0;
			e_count  = '0;
			e_seen   = '0;
			e_rhp    = '0;
			e_in_run = 1'b0;
		end else begin
			e_hdr    = hdr_pos_q;
			e_width  = width_q;
			e_height = height_q;
			e_row    = row_q;
			e_start  = start_q;
			e_count  = count_q;
			e_seen   = seen_q;
			e_rhp    = rhp_q;
			e_in_run = in_run_q;
		end
		n_hdr    = e_hdr;
		n_width  = e_width;
		n_height = e_height;
		n_row    = e_row;
		n_start  = e_start;
		n_count  = e_count;
		n_seen   = e_seen;
		n_rhp    = e_rhp;
		n_in_run = e_in_run;
		req0     = '0;
		req1     = '0;
		col      = {1'b0, e_start} + {1'b0, e_seen};
		col_p1   = col + 17'd1;
		stop     = {1'b0, e_start} + {1'b0, e_count};
		seen_p1  = {1'b0, e_seen} + 17'd1;
		lead     = '0;

		if (e_hdr < csrb_pkg::HDR_POS_W'(csrb_pkg::HDR_BYTES)) begin
			// Header: pick up width and height
			if (e_hdr == csrb_pkg::HDR_POS_W'(2)) n_width[7:0]   = s_axis_tdata;
			if (e_hdr == csrb_pkg::HDR_POS_W'(3)) n_width[15:8]  = s_axis_tdata;
			if (e_hdr == csrb_pkg::HDR_POS_W'(4)) n_height[7:0]  = s_axis_tdata;
			if (e_hdr == csrb_pkg::HDR_POS_W'(5)) n_height[15:8] = s_axis_tdata;
			n_hdr = e_hdr + csrb_pkg::HDR_POS_W'(1);
			if (n_hdr == csrb_pkg::HDR_POS_W'(csrb_pkg::HDR_BYTES)) begin
				n_row    = '0;
				n_rhp    = '0;
				n_seen   = '0;
				n_in_run = 1'b0;
			end
		end else if (e_row >= e_height) begin
			// Idle: drop the byte
		end else if (!e_in_run) begin
			// Row header: start column then run count
			case (e_rhp)
				2'd0:    n_start = {8'd0, s_axis_tdata};
				2'd1:    n_start = {s_axis_tdata, e_start[7:0]};
				2'd2:    n_count = {8'd0, s_axis_tdata};
				default: n_count = {s_axis_tdata, e_count[7:0]};
			endcase
			if (e_rhp != 2'd3) begin
				n_rhp = e_rhp + 2'd1;
			end else if (n_count == 16'd0) begin
				req0.en    = 1'b1;
				req0.col_b = {1'b0, e_width};
				n_in_run   = 1'b0;
				n_rhp      = '0;
				n_seen     = '0;
				n_row      = e_row + 16'd1;
			end else begin
				lead       = (e_start < e_width) ? e_start : e_width;
				req0.en    = 1'b1;
				req0.col_b = {1'b0, lead};
				n_in_run   = 1'b1;
				n_seen     = '0;
			end
		end else begin
			// Run: one pixel, and the trailing span on the last byte
			if (col < {1'b0, e_width}) begin
				req0.en     = 1'b1;
				req0.col_a  = col;
				req0.col_b  = col_p1;
				req0.colour = s_axis_tdata;
			end
			n_seen = seen_p1[15:0];
			if (seen_p1 >= {1'b0, e_count}) begin
				if (stop < {1'b0, e_width}) begin
					req1.en    = 1'b1;
					req1.col_a = stop;
					req1.col_b = {1'b0, e_width};
				end
				n_in_run = 1'b0;
				n_rhp    = '0;
				n_seen   = '0;
				n_row    = e_row + 16'd1;
			end
		end
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q <= csrb_pkg::HDR_POS_W'(csrb_pkg::HDR_BYTES);
			width_q   <= '0;
			height_q  <= '0;
			row_q     <= '0;
			start_q   <= '0;
			count_q   <= '0;
			seen_q    <= '0;
			rhp_q     <= '0;
			in_run_q  <= 1'b0;
		end else if (s_accept) begin
			hdr_pos_q <= n_hdr;
			width_q   <= n_width;
			height_q  <= n_height;
			row_q     <= n_row;
			start_q   <= n_start;
			count_q   <= n_count;
			seen_q    <= n_seen;
			rhp_q     <= n_rhp;
			in_run_q  <= n_in_run;
		end
	end

	// Stage 2 takes a new request once its last span leaves
	assign s2_free = !(res0_s2.ok || res1_s2.ok) || (m_accept && m_axis_tlast);
	assign s_axis_tready = !valid_s1 || s2_free;

	// Stage 1: registered span requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= req0.en || req1.en;
		end else if (s2_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req0_s1 <= req0;
			req1_s1 <= req1;
			row_s1  <= e_row;
		end
	end

	// Clip both requests
	always_comb begin
		clip0 = clip_span(req0_s1, row_s1, origin_x_q, origin_y_q, clip_left_q,
			clip_right_q, clip_top_q, clip_bottom_q, transparent_q);
		clip1 = clip_span(req1_s1, row_s1, origin_x_q, origin_y_q, clip_left_q,
			clip_right_q, clip_top_q, clip_bottom_q, transparent_q);
	end

	// Stage 2: result register, drained one span per output request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res0_s2 <= '0;
			res1_s2 <= '0;
		end else if (valid_s1 && s2_free) begin
			res0_s2 <= clip0;
			res1_s2 <= clip1;
		end else if (m_accept) begin
			if (res0_s2.ok) res0_s2.ok <= 1'b0;
			else            res1_s2.ok <= 1'b0;
		end
	end

	// Present the first pending span
	assign out_span      = res0_s2.ok ? res0_s2 : res1_s2;
	assign m_axis_tvalid = res0_s2.ok || res1_s2.ok;
	assign m_axis_tlast  = !(res0_s2.ok && res1_s2.ok);
	assign m_axis_tdata  = {3'b000, out_span.colour, out_span.len, out_span.y, out_span.x};

	// Checks
	assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q |-> (rhp_q == 2'd3) && (row_q < height_q))
		else $error("run phase outside a row body");

	assert property (@(posedge clk) disable iff (!arst_n)
		hdr_pos_q <= csrb_pkg::HDR_POS_W'(csrb_pkg::HDR_BYTES))
		else $error("header position past header end");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1)
		else $error("stage 1 request lost while stage 2 busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_span.len != '0)
			&& (out_span.x < 10'(csrb_pkg::SCREEN_W))
			&& (out_span.y < 9'(csrb_pkg::SCREEN_H)))
		else $error("span outside screen or empty");

endmodule
